FILE: hw/rtl/pal_pkg.sv
// Shared types and constants for the positional array list.
`timescale 1ns / 1ps
`default_nettype none

package pal_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int POS_W        = 7;
    localparam int WORD_W       = 32;
    localparam int LEN_W        = 8;
    localparam int OP_W         = 3;
    localparam int STAT_W       = 2;

    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd1;
    localparam logic [OP_W-1:0] OP_OVERWRITE = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE    = 3'd3;
    localparam logic [OP_W-1:0] OP_READ      = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] word_in;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] word_out;
        logic [LEN_W-1:0]         list_length;
    } rsp_t;

endpackage

`default_nettype wire

FILE: hw/rtl/pal_mem.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module pal_mem #(
    parameter int DEPTH = pal_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [AW-1:0]                 wr_addr,
    input  wire logic [pal_pkg::WORD_W-1:0]    wr_data,
    input  wire logic                          rd_en,
    input  wire logic [AW-1:0]                 rd_addr,
    output logic      [pal_pkg::WORD_W-1:0]    rd_data
);
    import pal_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/positional_array_list.sv
// Top level: ordered list of signed words with insert, delete, overwrite and read.
// Clear, append, full, bad-index and last-entry delete go from S_IDLE to S_DONE;
// read/overwrite pass S_READ; insert shifts in S_UP then S_INS, delete in S_DN.
// One entry moves per cycle through the single write port of the entry store.
// The result word goes from res_reg into an output register, which waits on rsp_stall.
// Reset empties the list at once; entry contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_array_list #(
    parameter int CAPACITY = pal_pkg::CAPACITY_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire pal_pkg::req_t req_word,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output pal_pkg::rsp_t      rsp_word
);
    import pal_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > LEN_W) ? CW : LEN_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UP,
        S_INS,
        S_DN,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     src_reg, src_next;
    logic [WORD_W-1:0] word_reg, word_next;
    rsp_t              res_reg, res_next;
    rsp_t              out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              wr_en, rd_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0] wr_data, rd_data;

    logic [CMPW-1:0]   pos_ext, cnt_ext;
    logic              in_range, full;
    logic [CW-1:0]     count_inc, count_dec;

    pal_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign pos_ext   = CMPW'(req_word.position);
    assign cnt_ext   = CMPW'(count_reg);
    assign in_range  = pos_ext < cnt_ext;
    assign full      = count_reg == CW'(CAPACITY);
    assign count_inc = count_reg + CW'(1);
    assign count_dec = count_reg - CW'(1);

    assign req_stall = state_reg != S_IDLE;
    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        src_next       = src_reg;
        word_next      = word_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = '0;
        rd_en          = 1'b0;
        rd_addr        = '0;

        if (!rsp_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    word_next  = req_word.word_in;
                    pos_next   = AW'(req_word.position);
                    state_next = S_DONE;
                    res_next   = '{status: STAT_OK, word_out: '0,
                                   list_length: LEN_W'(count_reg)};
                    unique case (req_word.op)
                        OP_CLEAR:
                        begin
                            count_next           = '0;
                            res_next.list_length = '0;
                        end
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else if (!in_range)
                            begin
                                wr_en                = 1'b1;
                                wr_addr              = AW'(count_reg);
                                wr_data              = req_word.word_in;
                                count_next           = count_inc;
                                res_next.list_length = LEN_W'(count_inc);
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(count_dec);
                                src_next   = AW'(count_dec);
                                state_next = S_UP;
                            end
                        end
                        OP_OVERWRITE:
                        begin
                            if (!in_range)
                            begin
                                res_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(req_word.position);
                                wr_en      = 1'b1;
                                wr_addr    = AW'(req_word.position);
                                wr_data    = req_word.word_in;
                                state_next = S_READ;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (!in_range)
                            begin
                                res_next.status = STAT_RANGE;
                            end
                            else if ((pos_ext + CMPW'(1)) < cnt_ext)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(pos_ext + CMPW'(1));
                                src_next   = AW'(pos_ext + CMPW'(1));
                                state_next = S_DN;
                            end
                            else
                            begin
                                count_next           = count_dec;
                                res_next.list_length = LEN_W'(count_dec);
                            end
                        end
                        OP_READ:
                        begin
                            if (!in_range)
                            begin
                                res_next.status = STAT_RANGE;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = AW'(req_word.position);
                                state_next = S_READ;
                            end
                        end
                        default:
                        begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_next   = '{status: STAT_OK, word_out: rd_data,
                               list_length: LEN_W'(count_reg)};
                state_next = S_DONE;
            end
            S_UP:
            begin
                wr_en   = 1'b1;
                wr_addr = src_reg + AW'(1);
                wr_data = rd_data;
                if (src_reg == pos_reg)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = src_reg - AW'(1);
                    src_next = src_reg - AW'(1);
                end
            end
            S_INS:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = word_reg;
                count_next = count_inc;
                res_next   = '{status: STAT_OK, word_out: '0,
                               list_length: LEN_W'(count_inc)};
                state_next = S_DONE;
            end
            S_DN:
            begin
                wr_en   = 1'b1;
                wr_addr = src_reg - AW'(1);
                wr_data = rd_data;
                if (src_reg == AW'(count_dec))
                begin
                    count_next = count_dec;
                    res_next   = '{status: STAT_OK, word_out: '0,
                                   list_length: LEN_W'(count_dec)};
                    state_next = S_DONE;
                end
                else
                begin
                    rd_en    = 1'b1;
                    rd_addr  = src_reg + AW'(1);
                    src_next = src_reg + AW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        src_reg  <= src_next;
        word_reg <= word_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire
